>>> src/mtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_pkg
// Types, constants and helper functions for the magnetometer trim compensation
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int QueueDepth = 4;

  typedef enum logic [2:0] {
    REG_X_PACK   = 3'd0,
    REG_Y_PACK   = 3'd1,
    REG_XY_PACK  = 3'd2,
    REG_Z1       = 3'd3,
    REG_Z2       = 3'd4,
    REG_Z3       = 3'd5,
    REG_Z4       = 3'd6,
    REG_XYZ1     = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [15:0] x_word;
    logic [15:0] y_word;
    logic [15:0] z_word;
    logic [15:0] r_word;
  } in_item_t;

  typedef struct packed {
    logic               ready_res;
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic signed [15:0] field_z;
    logic               divide_fault;
  } out_item_t;

  typedef struct packed {
    logic [15:0] x_pack;
    logic [15:0] y_pack;
    logic [15:0] xy_pack;
    logic [15:0] z1;
    logic [15:0] z2;
    logic [15:0] z3;
    logic [15:0] z4;
    logic [14:0] xyz1;
  } trim_t;

  // classified item handed from front to back
  typedef struct packed {
    logic               ready;
    logic               tfault;
    logic signed [13:0] mx;
    logic signed [13:0] my;
    logic signed [15:0] znum_hi;
    logic signed [31:0] znum;
    logic signed [17:0] zdiv;
    logic [29:0]        tnum;
    logic [14:0]        tden;
  } work_t;

endpackage

>>> src/mtc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_front
// Unpacks a raw reading and forms the divider operands, two pipeline stages
// ----------------------------------------------------------------------------
module mtc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  mtc_pkg::in_item_t in_data,
  input  mtc_pkg::trim_t    trim,
  input  logic              advance,
  output logic              out_valid,
  output mtc_pkg::work_t    out_data
);

  logic                v1;
  mtc_pkg::in_item_t   d1;
  logic signed [31:0]  p3;
  logic [31:0]         p1;
  logic [13:0]         rr_c;

  assign rr_c = in_data.r_word[15:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (advance) begin
      d1 <= in_data;
      p3 <= $signed(trim.z3) * $signed({3'b0, rr_c} - {2'b0, trim.xyz1});
      p1 <= {16'b0, trim.z1} * {17'b0, rr_c, 1'b0};
    end
  end

  logic [13:0]        rr;
  logic [14:0]        tden;
  logic signed [16:0] mz;
  logic signed [31:0] znum;
  logic [31:0]        zt;
  logic signed [17:0] zdiv;

  always_comb begin
    rr   = d1.r_word[15:2];
    tden = (rr != 14'd0) ? {1'b0, rr} : trim.xyz1;
    mz   = $signed({d1.z_word[15], d1.z_word[15:1]}) - $signed(trim.z4);
    znum = ($signed({{15{mz[16]}}, mz}) <<< 15) - (p3 >>> 2);
    zt   = p1 + 32'd32768;
    zdiv = $signed({{2{trim.z2[15]}}, trim.z2}) + $signed({{2{zt[31]}}, zt[31:16]});
  end

  // stage 2: operands
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.ready   <= d1.r_word[0];
      out_data.tfault  <= (tden == 15'd0);
      out_data.mx      <= $signed(d1.x_word[15:3]);
      out_data.my      <= $signed(d1.y_word[15:3]);
      out_data.znum_hi <= znum[31:16];
      out_data.znum    <= znum;
      out_data.zdiv    <= zdiv;
      out_data.tnum    <= {1'b0, trim.xyz1, 14'b0};
      out_data.tden    <= tden;
    end
  end

endmodule

>>> src/mtc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_queue
// Small register FIFO between the front and the back
// ----------------------------------------------------------------------------
module mtc_queue #(
  parameter int Depth = mtc_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mtc_pkg::work_t push_data,
  input  logic           pop,
  output logic           not_empty,
  output logic [$clog2(Depth+1)-1:0] count,
  output mtc_pkg::work_t pop_data
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  mtc_pkg::work_t mem [Depth];
  logic [AW-1:0]  wp, rp;

  assign not_empty = (count != '0);
  assign pop_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

endmodule

>>> src/mtc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_back
// Pipelined dividers and axis compensation, stalls as a whole
// ----------------------------------------------------------------------------
module mtc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  mtc_pkg::work_t    in_data,
  input  mtc_pkg::trim_t    trim,
  input  logic              en,
  output logic              out_valid,
  output mtc_pkg::out_item_t out_data
);

  localparam int TN = 30;   // temperature divider steps, unsigned
  localparam int ZN = 32;   // z divider steps on magnitudes
  localparam int AX = 6;    // axis stages
  localparam int L  = ZN + AX;

  // ---- z divider: restoring, one quotient bit per stage ----
  logic [31:0] zr [ZN+1];
  logic [31:0] zq [ZN+1];
  logic [17:0] zd [ZN+1];
  logic        zneg [ZN+1];
  logic        zzero [ZN+1];

  // ---- temperature divider ----
  logic [29:0] tr [TN+1];
  logic [29:0] tq [TN+1];
  logic [14:0] td [TN+1];

  logic [L:0]  vld;
  mtc_pkg::work_t side [L+1];

  assign zr[0]    = '0;
  assign zq[0]    = in_data.znum[31] ? 32'(-in_data.znum) : 32'(in_data.znum);
  assign zd[0]    = in_data.zdiv[17] ? 18'(-in_data.zdiv) : 18'(in_data.zdiv);
  assign zneg[0]  = in_data.znum[31] ^ in_data.zdiv[17];
  assign zzero[0] = (in_data.zdiv == '0);
  assign tr[0]    = '0;
  assign tq[0]    = in_data.tnum;
  assign td[0]    = in_data.tden;
  assign vld[0]   = in_valid;
  assign side[0]  = in_data;

  for (genvar i = 0; i < ZN; i++) begin : g_z
    logic [32:0] rem;
    logic [50:0] tr_s;
    assign rem = {zr[i], zq[i][31]};
    assign tr_s = {18'b0, rem} - {33'b0, zd[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        // remainder kept in zr, dividend bits shift out of zq
        if (!tr_s[50]) begin
          zr[i+1] <= tr_s[31:0];
          zq[i+1] <= {zq[i][30:0], 1'b1};
        end else begin
          zr[i+1] <= rem[31:0];
          zq[i+1] <= {zq[i][30:0], 1'b0};
        end
        zd[i+1] <= zd[i];
        zneg[i+1] <= zneg[i];
        zzero[i+1] <= zzero[i];
        side[i+1] <= side[i];
      end
    end
  end

  for (genvar i = 0; i < TN; i++) begin : g_t
    logic [30:0] rem;
    logic [30:0] dif;
    assign rem = {tr[i], tq[i][29]};
    assign dif = rem - {16'b0, td[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!dif[30]) begin
          tr[i+1] <= dif[29:0];
          tq[i+1] <= {tq[i][28:0], 1'b1};
        end else begin
          tr[i+1] <= rem[29:0];
          tq[i+1] <= {tq[i][28:0], 1'b0};
        end
        td[i+1] <= td[i];
      end
    end
  end

  // quotient bits land in low bits as dividend shifts; restoring with dividend in zq
  logic [31:0] zmag;
  assign zmag = zq[ZN];

  // align temperature quotient to z pipeline
  logic [15:0] tdly [ZN-TN+1];
  assign tdly[0] = tq[TN][15:0];
  for (genvar i = 0; i < ZN - TN; i++) begin : g_td
    always_ff @(posedge clk) begin
      if (en) tdly[i+1] <= tdly[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[L:1] <= '0;
    else if (en) vld[L:1] <= vld[L-1:0];
  end

  // ---- axis stages ----
  logic signed [15:0] temp, fz_w;
  logic signed [31:0] zsq;
  assign temp = $signed(tdly[ZN-TN] - 16'h4000);
  assign zsq  = zneg[ZN] ? -$signed(zmag) : $signed(zmag);
  assign fz_w = zzero[ZN] ? 16'sd0 : zsq[15:0];

  logic signed [7:0]  xy2, gx, gy, ox, oy;
  logic [7:0]         xy1;
  assign xy2 = trim.xy_pack[15:8];
  assign xy1 = trim.xy_pack[7:0];
  assign gx  = trim.x_pack[15:8];
  assign ox  = trim.x_pack[7:0];
  assign gy  = trim.y_pack[15:8];
  assign oy  = trim.y_pack[7:0];

  // a1: t*t, t*xy1
  logic signed [31:0] a_tt, a_tx;
  logic signed [15:0] fz1, fz2, fz3, fz4, fz5;
  always_ff @(posedge clk) begin
    if (en) begin
      a_tt <= temp * temp;
      a_tx <= temp * $signed({1'b0, xy1, 7'b0});
      fz1  <= fz_w;
    end
  end
  // a2: s
  logic signed [31:0] a_s;
  always_ff @(posedge clk) begin
    if (en) begin
      a_s <= 32'($signed(xy2) * (a_tt >>> 7)) + a_tx;
      fz2 <= fz1;
    end
  end
  // a3: f per axis
  logic signed [31:0] fxr, fyr, sb;
  assign sb = (a_s >>> 9) + 32'sh100000;
  always_ff @(posedge clk) begin
    if (en) begin
      fxr <= 32'(sb * ($signed({{8{gx[7]}}, gx}) + 16'sd160));
      fyr <= 32'(sb * ($signed({{8{gy[7]}}, gy}) + 16'sd160));
      fz3 <= fz2;
    end
  end
  // a4: p
  logic signed [31:0] px, py;
  always_ff @(posedge clk) begin
    if (en) begin
      px <= 32'(side[ZN+3].mx * (fxr >>> 12));
      py <= 32'(side[ZN+3].my * (fyr >>> 12));
      fz4 <= fz3;
    end
  end
  // a5: offsets
  logic signed [31:0] rx, ry;
  always_ff @(posedge clk) begin
    if (en) begin
      rx <= (px >>> 13) + 32'($signed(ox) * 8);
      ry <= (py >>> 13) + 32'($signed(oy) * 8);
      fz5 <= fz4;
    end
  end
  // side band delayed through axis stages
  for (genvar i = ZN; i < L; i++) begin : g_sd
    always_ff @(posedge clk) begin
      if (en) side[i+1] <= side[i];
    end
  end
  logic zz_d [AX+1];
  assign zz_d[0] = zzero[ZN];
  for (genvar i = 0; i < AX; i++) begin : g_zz
    always_ff @(posedge clk) begin
      if (en) zz_d[i+1] <= zz_d[i];
    end
  end

  // a6: final
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.ready_res <= side[ZN+5].ready;
      if (!side[ZN+5].ready) begin
        out_data.field_x <= '0;
        out_data.field_y <= '0;
        out_data.field_z <= '0;
        out_data.divide_fault <= 1'b0;
      end else begin
        out_data.field_x <= side[ZN+5].tfault ? 16'sd0 : rx[15:0];
        out_data.field_y <= side[ZN+5].tfault ? 16'sd0 : ry[15:0];
        out_data.field_z <= fz5;
        out_data.divide_fault <= side[ZN+5].tfault | zz_d[5];
      end
    end
  end
  assign out_valid = vld[L];

endmodule

>>> src/magnetometer_trim_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_trim_compensation
// Integer temperature compensation of raw magnetometer readings
// ----------------------------------------------------------------------------
// in_valid/in_stall/in_data carry one raw reading per transaction; out_valid/
// out_stall/out_data return one compensated result per reading, in order.
// cfg_valid/cfg_ready/cfg_index/cfg_data write the trim registers; write
// them only while idle.
// Throughput: one reading per cycle while in_stall is low. A reading passes the two
// front stages, one queue slot, the 32-stage z divider and six axis stages.
// The back pipeline advances only when its output slot is free or taken;
// when the receiver stalls, the queue absorbs readings still in the front
// and in_stall rises once the queue cannot take them.
// Reset clears all trim registers, the queue and every valid bit.
// ----------------------------------------------------------------------------
module magnetometer_trim_compensation #(
  parameter int QueueDepth = mtc_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mtc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mtc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  mtc_pkg::trim_t trim;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim <= '0;
    end else if (cfg_valid) begin
      unique case (mtc_pkg::reg_index_t'(cfg_index))
        mtc_pkg::REG_X_PACK:  trim.x_pack  <= cfg_data;
        mtc_pkg::REG_Y_PACK:  trim.y_pack  <= cfg_data;
        mtc_pkg::REG_XY_PACK: trim.xy_pack <= cfg_data;
        mtc_pkg::REG_Z1:      trim.z1      <= cfg_data;
        mtc_pkg::REG_Z2:      trim.z2      <= cfg_data;
        mtc_pkg::REG_Z3:      trim.z3      <= cfg_data;
        mtc_pkg::REG_Z4:      trim.z4      <= cfg_data;
        mtc_pkg::REG_XYZ1:    trim.xyz1    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  localparam int CW = $clog2(QueueDepth + 1);

  logic           f_valid, q_ne, q_pop, b_en;
  mtc_pkg::work_t f_data, q_data;
  logic [CW-1:0]  q_cnt;
  logic [1:0]     q_infl;

  // front holds at most two in flight; keep room for them
  assign in_stall = (q_cnt > CW'(QueueDepth - 3));
  assign q_infl   = '0;

  mtc_front u_front (
    .clk, .rst, .in_valid(in_valid && !in_stall), .in_data, .trim,
    .advance(1'b1), .out_valid(f_valid), .out_data(f_data)
  );

  assign b_en  = !out_valid || !out_stall;
  assign q_pop = q_ne && b_en;

  mtc_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .push(f_valid), .push_data(f_data), .pop(q_pop),
    .not_empty(q_ne), .count(q_cnt), .pop_data(q_data)
  );

  logic b_out_valid;
  mtc_back u_back (
    .clk, .rst, .in_valid(q_pop), .in_data(q_data), .trim, .en(b_en),
    .out_valid(b_out_valid), .out_data
  );
  assign out_valid = b_out_valid;

  mtc_count_never_over: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= CW'(QueueDepth)) else $error("queue overflow");
  mtc_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_cnt != '0) else $error("pop from empty queue");
  mtc_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("result lost under stall");
  mtc_infl_zero: assert property (@(posedge clk) q_infl == 2'd0)
    else $error("in-flight tracker");

endmodule

>>> test/mtc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_checker
// Watches the reading, result and trim write channels of the magnetometer
// trim compensation, computes the expected compensated fields for every
// accepted reading from its own copy of the trims and compares each result
// against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module mtc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  mtc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  mtc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  mtc_pkg::trim_t     trims;
  mtc_pkg::out_item_t field_queue[$];

  function automatic longint sx8(logic [7:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint sx16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint wrap32(longint v);
    int t;
    t = int'(v);
    return longint'(t);
  endfunction

  function automatic logic [15:0] axis_field(longint raw, longint temp, logic [15:0] pack,
                                             logic [15:0] xy_pack);
    longint off, gain, xy1, xy2, t2, s, f, p, r;
    off  = sx8(pack[7:0]);
    gain = sx8(pack[15:8]);
    xy1  = longint'(xy_pack[7:0]);
    xy2  = sx8(xy_pack[15:8]);
    t2   = (temp * temp) >>> 7;
    s    = wrap32(xy2 * t2 + temp * (xy1 * 128));
    f    = wrap32(((s >>> 9) + 64'sh100000) * (gain + 64'shA0));
    p    = wrap32(raw * (f >>> 12));
    r    = (p >>> 13) + off * 8;
    return r[15:0];
  endfunction

  function automatic mtc_pkg::out_item_t compensate(mtc_pkg::in_item_t d,
                                                    mtc_pkg::trim_t tr);
    mtc_pkg::out_item_t o;
    longint mx, my, mz, rr, xyz1, tdiv, q, temp, znum, zdiv, zq;
    o = '0;
    if (d.r_word[0]) begin
      o.ready_res = 1'b1;
      mx   = sx16(d.x_word) >>> 3;
      my   = sx16(d.y_word) >>> 3;
      mz   = sx16(d.z_word) >>> 1;
      rr   = longint'(d.r_word[15:2]);
      xyz1 = longint'(tr.xyz1);
      tdiv = (rr != 0) ? rr : xyz1;
      if (tdiv == 0) begin
        o.divide_fault = 1'b1;
      end else begin
        q    = (xyz1 * 16384) / tdiv;
        temp = sx16(16'(q - 16384));
        o.field_x = axis_field(mx, temp, tr.x_pack, tr.xy_pack);
        o.field_y = axis_field(my, temp, tr.y_pack, tr.xy_pack);
      end
      znum = wrap32((mz - sx16(tr.z4)) * 32768
                    - (wrap32(sx16(tr.z3) * (rr - xyz1)) >>> 2));
      zdiv = sx16(tr.z2)
           + sx16(16'(wrap32(longint'(tr.z1) * (rr * 2) + 32768) >>> 16));
      if (zdiv == 0) begin
        o.divide_fault = 1'b1;
      end else begin
        zq = wrap32(znum / zdiv);
        o.field_z = zq[15:0];
      end
    end
    return o;
  endfunction

  assign pending = field_queue.size();

  always @(posedge clk) begin
    mtc_pkg::out_item_t want;
    if (rst) begin
      trims <= '0;
      field_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (mtc_pkg::reg_index_t'(cfg_index))
          mtc_pkg::REG_X_PACK:  trims.x_pack  <= cfg_data;
          mtc_pkg::REG_Y_PACK:  trims.y_pack  <= cfg_data;
          mtc_pkg::REG_XY_PACK: trims.xy_pack <= cfg_data;
          mtc_pkg::REG_Z1:      trims.z1      <= cfg_data;
          mtc_pkg::REG_Z2:      trims.z2      <= cfg_data;
          mtc_pkg::REG_Z3:      trims.z3      <= cfg_data;
          mtc_pkg::REG_Z4:      trims.z4      <= cfg_data;
          mtc_pkg::REG_XYZ1:    trims.xyz1    <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) field_queue.push_back(compensate(in_data, trims));
      if (out_valid && !out_stall) begin
        if (field_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = field_queue.pop_front();
          if (want !== out_data) begin
            if (fail_count < 10)
              $display("mismatch: rdy %b/%b x %0d/%0d y %0d/%0d z %0d/%0d fault %b/%b",
                       want.ready_res, out_data.ready_res, want.field_x, out_data.field_x,
                       want.field_y, out_data.field_y, want.field_z, out_data.field_z,
                       want.divide_fault, out_data.divide_fault);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives raw readings and trim writes into the magnetometer trim compensation
// across several trim settings, with random idle bursts on both sides and one
// long receiver hold-off, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  mtc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mtc_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending;
  bit                 steady = 1'b0;
  bit                 hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  magnetometer_trim_compensation dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  mtc_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  // receiver stall bursts
  initial begin
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic write_trim(mtc_pkg::reg_index_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_trims(mtc_pkg::trim_t t);
    write_trim(mtc_pkg::REG_X_PACK, t.x_pack);
    write_trim(mtc_pkg::REG_Y_PACK, t.y_pack);
    write_trim(mtc_pkg::REG_XY_PACK, t.xy_pack);
    write_trim(mtc_pkg::REG_Z1, t.z1);
    write_trim(mtc_pkg::REG_Z2, t.z2);
    write_trim(mtc_pkg::REG_Z3, t.z3);
    write_trim(mtc_pkg::REG_Z4, t.z4);
    write_trim(mtc_pkg::REG_XYZ1, {1'b0, t.xyz1});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_reading(mtc_pkg::in_item_t d);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_directed();
    logic [15:0] edges[4] = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
    mtc_pkg::in_item_t d;
    for (int i = 0; i < 4; i++) begin
      d = '{edges[i], edges[(i + 1) % 4], edges[(i + 2) % 4], 16'hFFFD};
      send_reading(d);
      d.r_word = 16'h0001;
      send_reading(d);
      d.r_word = 16'hFFFC;
      send_reading(d);
    end
    send_reading('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_reading('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_reading('{16'h1238, 16'hEDC8, 16'h0F02, 16'h6E35});
    send_reading('{16'h7FF8, 16'h8000, 16'h8001, 16'h0005});
  endtask

  task automatic run_random(int count);
    mtc_pkg::in_item_t d;
    for (int i = 0; i < count; i++) begin
      d.x_word = 16'($urandom);
      d.y_word = 16'($urandom);
      d.z_word = 16'($urandom);
      case ($urandom_range(0, 9))
        0:       d.r_word = 16'($urandom) & 16'hFFFE;
        1:       d.r_word = {14'd0, 1'b0, 1'b1} | (16'($urandom) & 16'h0002);
        2:       d.r_word = {14'($urandom_range(1, 16383)), 2'($urandom)} | 16'h0001;
        default: d.r_word = {14'($urandom_range(6000, 8000)), 2'($urandom)} | 16'h0001;
      endcase
      send_reading(d);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    mtc_pkg::trim_t t;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset trims: the z divisor is always zero, the temperature divisor for r = 0
    run_directed();
    run_random(100);
    drain();

    // typical factory trims
    load_trims('{16'h1A00, 16'h1A00, 16'hFD1D, 16'd24747, 16'd763, 16'd0, 16'd0, 15'd7053});
    run_directed();
    hold_req = 1'b1;
    run_random(200);
    drain();

    // upper extremes
    load_trims('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                 15'h7FFF});
    run_directed();
    run_random(150);
    drain();

    // lower extremes, temperature divisor zero for r = 0
    load_trims('{16'h8080, 16'h8080, 16'h8000, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
                 15'h0000});
    run_directed();
    run_random(150);
    drain();

    for (int k = 0; k < 4; k++) begin
      t.x_pack  = 16'($urandom);
      t.y_pack  = 16'($urandom);
      t.xy_pack = 16'($urandom);
      t.z1      = 16'($urandom);
      t.z2      = (k == 1) ? 16'd0 : 16'($urandom);
      t.z3      = 16'($urandom);
      t.z4      = 16'($urandom);
      t.xyz1    = (k == 2) ? 15'd0 : 15'($urandom_range(4000, 32767));
      load_trims(t);
      if (k == 3) steady = 1'b1;
      run_random(150);
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
src/mtc_pkg.sv
src/mtc_front.sv
src/mtc_queue.sv
src/mtc_back.sv
src/magnetometer_trim_compensation.sv
test/mtc_checker.sv
test/tb_top.sv
